FILE: rtl/core/pegg_pkg.sv
// shared types and constants of the per-entity generation gate
`timescale 1ns / 1ps

package pegg_pkg;

  localparam int unsigned EntriesDefault = 64;
  localparam int unsigned IdWidth        = 32;
  localparam int unsigned GenWidth       = 8;

  typedef enum logic [1:0] {
    REQ_CONVERT = 2'd0,
    REQ_CARRY   = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_FLUSH   = 2'd3
  } req_e;

  typedef logic [IdWidth-1:0]  id_t;
  typedef logic [GenWidth-1:0] gen_t;

  // serial-number test: a is newer than or equal to b
  function automatic logic gen_at_least(gen_t a, gen_t b);
    gen_t d;
    d = a - b;
    return ~d[GenWidth-1];
  endfunction

endpackage

FILE: rtl/core/pegg_if.sv
// request and response channel interfaces of the generation gate
`timescale 1ns / 1ps

interface pegg_req_if import pegg_pkg::*; ();
  logic valid;
  logic ready;
  req_e req_type;
  id_t  entity_id;
  gen_t generation;

  modport source (output valid, output req_type, output entity_id, output generation,
                  input ready);
  modport sink   (input valid, input req_type, input entity_id, input generation,
                  output ready);
endinterface

interface pegg_rsp_if import pegg_pkg::*; ();
  logic valid;
  logic ready;
  logic accept;
  gen_t known_generation;
  logic table_full;

  modport source (output valid, output accept, output known_generation,
                  output table_full, input ready);
  modport sink   (input valid, input accept, input known_generation,
                  input table_full, output ready);
endinterface

FILE: rtl/core/per_entity_generation_gate_core.sv
// Stale packet filter with a per-entity generation table (top level).
// Each request transaction is captured in the input register, judged against every
// table entry at once by an associative match, and its verdict captured in the result
// register, from which the response is offered; one transaction is taken every cycle
// while the response side keeps up. The table update of a transaction lands at the
// same edge as its response, so the following transaction always sees it. The table
// holds ENTRIES entries in flip-flops; the combinational compare across all entries
// and the lowest-free-entry search set the clock period. A flush clears every entry
// of the table when it commits. After reset the table is empty and no warm-up is
// needed.
`timescale 1ns / 1ps

module per_entity_generation_gate_core import pegg_pkg::*; #(
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pegg_req_if.sink    req_i,
  pegg_rsp_if.source  rsp_o
);

  // input register
  logic  in_valid_q;
  req_e  in_type_q;
  id_t   in_id_q;
  gen_t  in_gen_q;

  // result register
  logic  out_valid_q;
  logic  accept_q;
  gen_t  known_q;
  logic  full_q;

  // table
  logic [ENTRIES-1:0] slot_valid_q, slot_valid_d;
  id_t                slot_entity_q [ENTRIES];
  gen_t               slot_gen_q    [ENTRIES];

  logic [ENTRIES-1:0] hit_vec, free_vec, free_first, wr_vec;
  logic               hit, any_free;
  gen_t               known;
  logic               accept_d, full_d, wr_entity;
  logic               advance, commit;

  assign advance     = ~out_valid_q | rsp_o.ready;
  assign commit      = in_valid_q & advance;
  assign req_i.ready = ~in_valid_q | advance;

  always_comb begin
    known = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = slot_valid_q[i] && (slot_entity_q[i] == in_id_q);
      if (hit_vec[i]) begin
        known = known | slot_gen_q[i];
      end
    end
  end

  assign hit        = |hit_vec;
  assign free_vec   = ~slot_valid_q;
  assign any_free   = |free_vec;
  // isolate the lowest free entry
  assign free_first = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});

  always_comb begin
    accept_d     = 1'b1;
    full_d       = 1'b0;
    wr_vec       = '0;
    wr_entity    = 1'b0;
    slot_valid_d = slot_valid_q;
    if (in_type_q == REQ_FLUSH) begin
      slot_valid_d = '0;
    end else if (in_gen_q != '0) begin
      if (in_type_q == REQ_CONVERT) begin
        if (hit && !gen_at_least(in_gen_q, known)) begin
          accept_d = 1'b0;
        end else if (hit) begin
          wr_vec = hit_vec;
        end else if (any_free) begin
          wr_vec       = free_first;
          wr_entity    = 1'b1;
          slot_valid_d = slot_valid_q | free_first;
        end else begin
          full_d = 1'b1;
        end
      end else if (!hit) begin
        accept_d = 1'b0;
      end else if (in_type_q == REQ_CARRY) begin
        accept_d = (in_gen_q == known);
      end else begin
        accept_d = gen_at_least(in_gen_q, known);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      slot_valid_q <= '0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (commit) begin
        slot_valid_q <= slot_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_type_q <= req_i.req_type;
      in_id_q   <= req_i.entity_id;
      in_gen_q  <= req_i.generation;
    end
    if (commit) begin
      accept_q <= accept_d;
      known_q  <= known;
      full_q   <= full_d;
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (commit && wr_vec[g]) begin
        slot_gen_q[g] <= in_gen_q;
        if (wr_entity) begin
          slot_entity_q[g] <= in_id_q;
        end
      end
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.accept           = accept_q;
  assign rsp_o.known_generation = known_q;
  assign rsp_o.table_full       = full_q;

endmodule

FILE: dv/tb_top.sv
// self-checking bench for the per-entity generation gate: directed and random packets
`timescale 1ns / 1ps

module tb_top;
  import pegg_pkg::*;

  localparam int unsigned TableSize = 64;
  localparam int unsigned PoolSize  = 80;
  localparam int unsigned RandItems = 1000;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    req_e kind;
    id_t  entity;
    gen_t gen;
  } packet_t;

  typedef struct packed {
    logic accept;
    gen_t known;
    logic full;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  pegg_req_if req_if ();
  pegg_rsp_if rsp_if ();

  per_entity_generation_gate_core #(.ENTRIES(TableSize)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow copy of the generation table
  logic    tbl_valid  [TableSize];
  id_t     tbl_entity [TableSize];
  gen_t    tbl_gen    [TableSize];

  packet_t  outgoing[$];
  verdict_t verdicts_due[$];
  packet_t  cur_pkt;

  int unsigned total_pkts;
  int unsigned taken;
  int unsigned checked;
  int unsigned errors;
  int unsigned cycles;
  int unsigned stall_left;
  bit          stall_done;
  int unsigned n_pass, n_drop, n_full, n_flush;

  id_t  pool    [PoolSize];
  gen_t pool_gen[PoolSize];

  always #4 clk_i = ~clk_i;

  // b is newer than or equal to a when the wrapped distance is under half the range
  function automatic bit not_older(gen_t b, gen_t a);
    gen_t gen_gap;
    gen_gap = b - a;
    return gen_gap < 8'd128;
  endfunction

  function automatic verdict_t gate_verdict(packet_t p);
    verdict_t v;
    int hit;
    int spare;
    hit   = -1;
    spare = -1;
    for (int i = TableSize - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_entity[i] == p.entity) hit = i;
      if (!tbl_valid[i]) spare = i;
    end
    v.accept = 1'b1;
    v.known  = (hit >= 0) ? tbl_gen[hit] : '0;
    v.full   = 1'b0;
    if (p.kind == REQ_FLUSH) begin
      for (int i = 0; i < TableSize; i++) tbl_valid[i] = 1'b0;
      n_flush++;
    end else if (p.gen != '0) begin
      if (p.kind == REQ_CONVERT) begin
        if (hit >= 0 && !not_older(p.gen, v.known)) begin
          v.accept = 1'b0;
        end else if (hit >= 0) begin
          tbl_gen[hit] = p.gen;
        end else if (spare >= 0) begin
          tbl_valid[spare]  = 1'b1;
          tbl_entity[spare] = p.entity;
          tbl_gen[spare]    = p.gen;
        end else begin
          v.full = 1'b1;
          n_full++;
        end
      end else if (hit < 0) begin
        v.accept = 1'b0;
      end else if (p.kind == REQ_CARRY) begin
        v.accept = (p.gen == v.known);
      end else begin
        v.accept = not_older(p.gen, v.known);
      end
    end
    if (v.accept) n_pass++;
    else n_drop++;
    return v;
  endfunction

  // mostly short gaps, a few long ones, and windows with no idling at all
  function automatic int unsigned pick_gap();
    int unsigned r;
    if ((cycles / 500) % 4 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_pkt(req_e k, id_t e, gen_t g);
    packet_t p;
    p.kind   = k;
    p.entity = e;
    p.gen    = g;
    outgoing.insert(outgoing.size(), p);
    total_pkts++;
  endtask

  // flush, then more new entities than the table holds
  task automatic fill_table();
    queue_pkt(REQ_FLUSH, $urandom, gen_t'($urandom));
    for (int i = 0; i < TableSize + 6; i++)
      queue_pkt(REQ_CONVERT, $urandom, gen_t'($urandom_range(1, 255)));
  endtask

  task automatic random_pkt();
    int unsigned r;
    int unsigned k;
    req_e kind;
    gen_t g;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, PoolSize - 1);
    if (r < 1) begin
      queue_pkt(REQ_FLUSH, pool[k], gen_t'($urandom));
    end else if (r < 5) begin
      queue_pkt(req_e'($urandom_range(0, 3)), $urandom, gen_t'($urandom));
    end else begin
      if (r < 50) kind = REQ_CONVERT;
      else if (r < 75) kind = REQ_CARRY;
      else kind = REQ_RELEASE;
      r = $urandom_range(0, 99);
      if (r < 8) g = '0;
      else if (r < 38) g = pool_gen[k];
      else if (r < 78) g = pool_gen[k] + gen_t'($urandom_range(0, 6)) - 8'd3;
      else if (r < 88) g = pool_gen[k] + gen_t'($urandom_range(127, 129));
      else g = gen_t'($urandom);
      if (kind == REQ_CONVERT && g != '0) pool_gen[k] = g;
      queue_pkt(kind, pool[k], g);
    end
  endtask

  // request driver
  always @(posedge clk_i) begin : drive_req
    int unsigned idle;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        verdicts_due.insert(verdicts_due.size(), gate_verdict(cur_pkt));
        taken++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (idle != 0) begin
          idle--;
          req_if.valid <= 1'b0;
        end else if (outgoing.size() != 0) begin
          cur_pkt = outgoing.pop_front();
          req_if.req_type   <= cur_pkt.kind;
          req_if.entity_id  <= cur_pkt.entity;
          req_if.generation <= cur_pkt.gen;
          req_if.valid      <= 1'b1;
          idle = pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long hold-off of the response side while requests keep coming
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!stall_done && taken >= 400) begin
        stall_left <= 300;
        stall_done <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // response monitor and checker
  always @(posedge clk_i) begin : watch_rsp
    verdict_t want;
    int unsigned idle;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        checked++;
        if (verdicts_due.size() == 0) begin
          $error("response transaction with no request outstanding");
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (rsp_if.accept !== want.accept) begin
            $error("accept mismatch: expected %0d, got %0d", want.accept, rsp_if.accept);
            errors++;
          end
          if (rsp_if.known_generation !== want.known) begin
            $error("known_generation mismatch: expected %0d, got %0d",
                   want.known, rsp_if.known_generation);
            errors++;
          end
          if (rsp_if.table_full !== want.full) begin
            $error("table_full mismatch: expected %0d, got %0d", want.full, rsp_if.table_full);
            errors++;
          end
        end
        idle = pick_gap();
      end
      if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
      end else if (idle != 0) begin
        idle--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_CONVERT;
    req_if.entity_id  = '0;
    req_if.generation = '0;
    rsp_if.ready      = 1'b0;
    for (int i = 0; i < TableSize; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_entity[i] = '0;
      tbl_gen[i]    = '0;
    end

    // directed: wrap boundaries, generation zero, unknown entities, flush
    queue_pkt(REQ_CONVERT, 32'h0000_0000, 8'd0);
    queue_pkt(REQ_CARRY,   32'h0000_0000, 8'd5);
    queue_pkt(REQ_RELEASE, 32'h0000_0000, 8'd5);
    queue_pkt(REQ_CONVERT, 32'hFFFF_FFFF, 8'd255);
    queue_pkt(REQ_CONVERT, 32'hFFFF_FFFF, 8'd127);
    queue_pkt(REQ_CONVERT, 32'hFFFF_FFFF, 8'd126);
    queue_pkt(REQ_CARRY,   32'hFFFF_FFFF, 8'd126);
    queue_pkt(REQ_CARRY,   32'hFFFF_FFFF, 8'd255);
    queue_pkt(REQ_CARRY,   32'hFFFF_FFFF, 8'd0);
    queue_pkt(REQ_RELEASE, 32'hFFFF_FFFF, 8'd125);
    queue_pkt(REQ_RELEASE, 32'hFFFF_FFFF, 8'd253);
    queue_pkt(REQ_RELEASE, 32'hFFFF_FFFF, 8'd254);
    queue_pkt(REQ_CONVERT, 32'h0000_0000, 8'd1);
    queue_pkt(REQ_CONVERT, 32'h0000_0000, 8'd0);
    queue_pkt(REQ_CONVERT, 32'hA5A5_A5A5, 8'h80);
    queue_pkt(REQ_CONVERT, 32'h5A5A_5A5A, 8'h7F);
    queue_pkt(REQ_CONVERT, 32'h0000_0000, 8'd1);
    queue_pkt(REQ_FLUSH,   32'hFFFF_FFFF, 8'hAA);
    queue_pkt(REQ_CARRY,   32'hFFFF_FFFF, 8'd126);
    queue_pkt(REQ_FLUSH,   32'h0000_0000, 8'd0);
    queue_pkt(REQ_RELEASE, 32'h0000_0000, 8'd0);
    queue_pkt(REQ_CONVERT, 32'h0000_0000, 8'd200);

    for (int i = 0; i < PoolSize; i++) begin
      pool[i]     = $urandom;
      pool_gen[i] = gen_t'($urandom_range(1, 255));
    end
    for (int i = 0; i < RandItems; i++) begin
      if (i == 300 || i == 700) fill_table();
      random_pkt();
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (taken != total_pkts || verdicts_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d packets judged, %0d responses checked in %0d cycles",
             taken, checked, cycles);
    $display("%0d passed, %0d dropped, %0d converts refused for a full table, %0d flushes",
             n_pass, n_drop, n_full, n_flush);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/pegg_pkg.sv
rtl/core/pegg_if.sv
rtl/core/per_entity_generation_gate_core.sv
dv/tb_top.sv
